>>> rtl/core/sensor_curve_interpolator_assert.svh
// assertion helpers for the sensor curve interpolator checkers
`ifndef SENSOR_CURVE_INTERPOLATOR_ASSERT_SVH
`define SENSOR_CURVE_INTERPOLATOR_ASSERT_SVH

// same-cycle implication
`define SCI_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sensor curve interpolator assertion failed");

// next-cycle implication
`define SCI_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sensor curve interpolator assertion failed");

`endif

>>> rtl/core/sci_pkg.sv
package sci_pkg;

  localparam int SciPoints = 8;

  localparam int XW       = 12;
  localparam int YW       = 32;
  // (y1 - y0) is YW+1 bits signed, (v - x0) is XW+1 bits signed
  localparam int ProdW    = YW + 1 + XW + 1;
  localparam int DivW     = ProdW;
  localparam int DivSteps = DivW / 2;
  localparam int CfgIdxW  = 1;

  localparam logic [CfgIdxW-1:0] REG_LOWER_LIMIT = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_UPPER_LIMIT = 1'b1;

  typedef enum logic {
    REQ_SAMPLE = 1'b0,
    REQ_WRITE  = 1'b1
  } sci_req_e;

  typedef enum logic [1:0] {
    FAULT_OK      = 2'd0,
    FAULT_LIMIT   = 2'd1,
    FAULT_SEGMENT = 2'd2
  } sci_fault_e;

  typedef struct packed {
    logic [XW-1:0] x;
    logic [YW-1:0] y;
  } sci_entry_t;

  typedef struct packed {
    logic            start;
    logic [DivW-1:0] dividend;
    logic [XW-1:0]   divisor;
  } sci_div_req_t;

  typedef struct packed {
    logic            done;
    logic [DivW-1:0] quotient;
  } sci_div_rsp_t;

endpackage

>>> rtl/core/sci_table.sv
module sci_table #(
  parameter int POINTS = sci_pkg::SciPoints
) (
  input  logic                      clk_i,
  input  logic                      wr_en_i,
  input  logic [$clog2(POINTS)-1:0] wr_addr_i,
  input  sci_pkg::sci_entry_t       wr_data_i,
  input  logic                      rd_en_i,
  input  logic [$clog2(POINTS)-1:0] rd_addr_i,
  output sci_pkg::sci_entry_t       rd_data_o
);
  import sci_pkg::*;

  sci_entry_t mem_q [POINTS];
  sci_entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> rtl/core/sci_div.sv
module sci_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sci_pkg::sci_div_req_t req_i,
  output sci_pkg::sci_div_rsp_t rsp_o
);
  import sci_pkg::*;

  localparam int CntW = $clog2(DivSteps + 1);

  logic            busy_q;
  logic            done_q;
  logic [CntW-1:0] cnt_q;
  logic [XW-1:0]   den_q;
  logic [XW-1:0]   rem_q;
  logic [DivW-1:0] quo_q;

  logic [XW-1:0]   rem_d;
  logic [DivW-1:0] quo_d;
  logic [XW:0]     trial;
  logic            qbit;

  // two restoring steps per cycle, remainder kept below a nonzero divisor
  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    trial = '0;
    qbit  = 1'b0;
    for (int s = 0; s < 2; s++) begin
      trial = {rem_d, quo_d[DivW-1]};
      if (trial >= {1'b0, den_q}) begin
        rem_d = XW'(trial - {1'b0, den_q});
        qbit  = 1'b1;
      end else begin
        rem_d = trial[XW-1:0];
        qbit  = 1'b0;
      end
      quo_d = {quo_d[DivW-2:0], qbit};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      // done pulses for one cycle after the last step
      done_q <= busy_q && !req_i.start && (cnt_q == CntW'(1));
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(DivSteps);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      den_q <= req_i.divisor;
      rem_q <= '0;
      quo_q <= req_i.dividend;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

>>> rtl/core/sensor_curve_interpolator.sv
// sensor curve interpolator: maps a calibrated voltage in mV to a signed Q16.16 value by
// piecewise linear interpolation over a breakpoint table of POINTS entries held in one
// synchronous RAM. A write transaction (req_type 1) loads one breakpoint;
// indexes at or above POINTS are dropped, and it returns nothing. A sample transaction
// (req_type 0) returns exactly one result: fault 1 with value 0 if the voltage lies outside
// [lower_limit_mv, upper_limit_mv] (crossed limits reject everything), fault 2 with value 0
// if no segment x[i] <= v < x[i+1] matches, else fault 0 and
// y[i] + (y[i+1]-y[i])*(v-x[i])/(x[i+1]-x[i]) with the quotient truncated toward zero.
// Sequence: a limit fault goes from ST_IDLE straight to ST_DONE; a hit on segment k walks
// the table up to entry k + 1 with one RAM read per cycle, then passes ST_MUL, ST_DIV_START
// and ST_DIV_WAIT on the 2-bit-per-cycle divider before ST_DONE hands the result over; a
// miss walks every entry of the table and then goes to ST_DONE. A full
// output register adds its stall. One sample is in flight at a time, but the next
// transaction is taken while the previous result still waits in the output register.
// The table is not cleared at reset: every breakpoint the walk can reach must be written
// first. Limit registers are written through the cfg port (index 0 lower, 1 upper), always
// ready; the user must write them only while the block is idle, the block does not enforce it.
module sensor_curve_interpolator #(
  parameter int POINTS = sci_pkg::SciPoints
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration writes
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [sci_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [sci_pkg::XW-1:0]            cfg_data_i,
  // input transactions
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              req_type_i,
  input  logic [sci_pkg::XW-1:0]            voltage_mv_i,
  input  logic [2:0]                        point_index_i,
  input  logic [sci_pkg::XW-1:0]            point_x_mv_i,
  input  logic signed [sci_pkg::YW-1:0]     point_y_i,
  // result transactions
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [sci_pkg::YW-1:0]     value_o,
  output logic [1:0]                        fault_o
);
  import sci_pkg::*;

  localparam int AW = $clog2(POINTS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_MUL,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_DONE
  } state_e;

  state_e state_q;

  // limit registers
  logic [XW-1:0] lower_q;
  logic [XW-1:0] upper_q;

  // walk and datapath registers
  logic [AW-1:0]          cnt_q;
  logic [XW-1:0]          v_q;
  sci_entry_t             prev_q;
  logic [YW-1:0]          y0_q;
  logic signed [YW:0]     dy_q;
  logic [XW-1:0]          dx_q;
  logic [XW-1:0]          den_q;
  logic signed [ProdW-1:0] prod_q;
  logic                   neg_q;
  logic [YW-1:0]          res_value_q;
  sci_fault_e             res_fault_q;

  // output register
  logic                   out_valid_q;
  logic [YW-1:0]          out_value_q;
  sci_fault_e             out_fault_q;

  // table ports
  logic          tbl_we;
  logic [AW-1:0] tbl_waddr;
  sci_entry_t    tbl_wdata;
  logic          tbl_re;
  logic [AW-1:0] tbl_raddr;
  sci_entry_t    tbl_rdata;

  sci_div_req_t  div_req;
  sci_div_rsp_t  div_rsp;

  logic          in_acc;
  logic          is_sample;
  logic          idx_ok;
  logic          in_limits;
  logic          seg_hit;
  logic          walk_last;
  logic          walk_next;
  logic [YW-1:0] quo_lo;
  logic [YW-1:0] res_value;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign is_sample   = (req_type_i == REQ_SAMPLE);

  // breakpoint writes beyond the table are dropped
  assign idx_ok    = (32'(point_index_i) < 32'(POINTS));
  assign in_limits = (voltage_mv_i >= lower_q) && (voltage_mv_i <= upper_q);

  assign tbl_we      = in_acc && (req_type_i == REQ_WRITE) && idx_ok;
  assign tbl_waddr   = AW'(point_index_i);
  assign tbl_wdata.x = point_x_mv_i;
  assign tbl_wdata.y = point_y_i;

  // the read issued last cycle returns entry cnt_q; prev_q holds entry cnt_q-1
  assign seg_hit   = (v_q >= prev_q.x) && (v_q < tbl_rdata.x);
  assign walk_last = (cnt_q == AW'(POINTS - 1));
  assign walk_next = (cnt_q == '0) || (!seg_hit && !walk_last);

  assign tbl_re    = (in_acc && is_sample && in_limits) || ((state_q == ST_WALK) && walk_next);
  assign tbl_raddr = (state_q == ST_IDLE) ? '0 : cnt_q + AW'(1);

  sci_table #(
    .POINTS(POINTS)
  ) u_table (
    .clk_i    (clk_i),
    .wr_en_i  (tbl_we),
    .wr_addr_i(tbl_waddr),
    .wr_data_i(tbl_wdata),
    .rd_en_i  (tbl_re),
    .rd_addr_i(tbl_raddr),
    .rd_data_o(tbl_rdata)
  );

  // unsigned divide of |product| by the segment width, sign put back afterwards
  assign div_req.start    = (state_q == ST_DIV_START);
  assign div_req.dividend = prod_q[ProdW-1] ? DivW'(-prod_q) : DivW'(prod_q);
  assign div_req.divisor  = den_q;

  sci_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  // the quotient is bounded by |y1 - y0|, only the low word matters after the add
  assign quo_lo    = div_rsp.quotient[YW-1:0];
  assign res_value = y0_q + (neg_q ? (~quo_lo + YW'(1)) : quo_lo);

  // control state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      lower_q     <= '0;
      upper_q     <= '1;
      out_valid_q <= 1'b0;
      out_value_q <= '0;
      out_fault_q <= FAULT_OK;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_LOWER_LIMIT: lower_q <= cfg_data_i;
          REG_UPPER_LIMIT: upper_q <= cfg_data_i;
          default: ;
        endcase
      end

      // drained result; in ST_DONE the hand-over below sets the register instead
      if (out_valid_q && out_ready_i && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_acc && is_sample) begin
            cnt_q   <= '0;
            state_q <= in_limits ? ST_WALK : ST_DONE;
          end
        end
        ST_WALK: begin
          if (cnt_q == '0) begin
            cnt_q <= cnt_q + AW'(1);
          end else if (seg_hit) begin
            state_q <= ST_MUL;
          end else if (walk_last) begin
            state_q <= ST_DONE;
          end else begin
            cnt_q <= cnt_q + AW'(1);
          end
        end
        ST_MUL: begin
          state_q <= ST_DIV_START;
        end
        ST_DIV_START: begin
          state_q <= ST_DIV_WAIT;
        end
        ST_DIV_WAIT: begin
          if (div_rsp.done) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          // hand over once the output register is free or being drained
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            out_value_q <= res_value_q;
            out_fault_q <= res_fault_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          v_q         <= voltage_mv_i;
          res_value_q <= '0;
          res_fault_q <= in_limits ? FAULT_SEGMENT : FAULT_LIMIT;
        end
      end
      ST_WALK: begin
        prev_q <= tbl_rdata;
        if (cnt_q != '0 && seg_hit) begin
          y0_q  <= prev_q.y;
          dy_q  <= $signed({tbl_rdata.y[YW-1], tbl_rdata.y})
                 - $signed({prev_q.y[YW-1], prev_q.y});
          dx_q  <= v_q - prev_q.x;
          den_q <= tbl_rdata.x - prev_q.x;
        end
      end
      ST_MUL: begin
        prod_q <= dy_q * $signed({1'b0, dx_q});
      end
      ST_DIV_START: begin
        neg_q <= prod_q[ProdW-1];
      end
      ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          res_value_q <= res_value;
          res_fault_q <= FAULT_OK;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = out_value_q;
  assign fault_o     = out_fault_q;

endmodule

>>> rtl/core/sci_checker.sv
`include "sensor_curve_interpolator_assert.svh"

module sci_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          req_type_i,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic signed [sci_pkg::YW-1:0] value_o,
  input logic [1:0]                    fault_o
);
  import sci_pkg::*;

  // a stalled result holds
  `SCI_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
                  out_valid_o && $stable(value_o) && $stable(fault_o))

  // faulted results carry a zero value
  `SCI_ASSERT_IMP(a_fault_zero, clk_i, rst_ni, out_valid_o && (fault_o != FAULT_OK), value_o == '0)

  // a sample transaction keeps the input side busy in the next cycle
  `SCI_ASSERT_NXT(a_sample_busy, clk_i, rst_ni,
                  in_valid_i && in_ready_o && (req_type_i == REQ_SAMPLE), !in_ready_o)

  // a new result only shows up after the block was working on a sample
  `SCI_ASSERT_IMP(a_result_after_work, clk_i, rst_ni, $rose(out_valid_o), !$past(in_ready_o))

endmodule

bind sensor_curve_interpolator sci_checker u_sci_checker (.*);

>>> dv/sci_reading_checker.sv
`timescale 1ns / 100ps

module sci_reading_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  logic [sci_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [sci_pkg::XW-1:0]          cfg_data_i,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  logic                            req_type_i,
  input  logic [sci_pkg::XW-1:0]          voltage_mv_i,
  input  logic [2:0]                      point_index_i,
  input  logic [sci_pkg::XW-1:0]          point_x_mv_i,
  input  logic signed [sci_pkg::YW-1:0]   point_y_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  logic signed [sci_pkg::YW-1:0]   value_i,
  input  logic [1:0]                      fault_i,
  output int                              mismatch_count_o,
  output int                              pending_o
);
  import sci_pkg::*;

  typedef struct packed {
    logic signed [YW-1:0] value;
    sci_fault_e           fault;
  } reading_t;

  logic [XW-1:0]        lower_mv;
  logic [XW-1:0]        upper_mv;
  logic [XW-1:0]        curve_x [SciPoints];
  logic signed [YW-1:0] curve_y [SciPoints];
  reading_t             expected_readings [$];
  reading_t             oldest;

  // limit check, then the first segment with x[i] <= v < x[i+1]
  function automatic reading_t interpolate_reading(input logic [XW-1:0] mv);
    reading_t r;
    longint   y0;
    longint   y1;
    longint   run;
    longint   span;
    longint   res;
    bit       hit;
    r.value = '0;
    r.fault = FAULT_SEGMENT;
    hit     = 1'b0;
    if (mv < lower_mv || mv > upper_mv) begin
      r.fault = FAULT_LIMIT;
    end else begin
      for (int i = 0; i < SciPoints - 1; i++) begin
        if (!hit && mv >= curve_x[i] && mv < curve_x[i+1]) begin
          hit  = 1'b1;
          y0   = curve_y[i];
          y1   = curve_y[i+1];
          run  = longint'(mv) - longint'(curve_x[i]);
          span = longint'(curve_x[i+1]) - longint'(curve_x[i]);
          // longint division truncates toward zero
          res     = y0 + (((y1 - y0) * run) / span);
          r.value = res[YW-1:0];
          r.fault = FAULT_OK;
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_mv = '0;
      upper_mv = '1;
      expected_readings.delete();
    end else begin
      // result side first: a result never leaves in the cycle its sample arrives
      if (out_valid_i && out_ready_i) begin
        if (expected_readings.size() == 0) begin
          mismatch_count_o++;
          $display("%0t: result with nothing expected, value %0d fault %0d",
                   $time, value_i, fault_i);
        end else begin
          oldest = expected_readings.pop_front();
          if (value_i !== oldest.value) begin
            mismatch_count_o++;
            $display("%0t: value mismatch, expected %0d, got %0d",
                     $time, oldest.value, value_i);
          end
          if (fault_i !== oldest.fault) begin
            mismatch_count_o++;
            $display("%0t: fault mismatch, expected %0d, got %0d",
                     $time, oldest.fault, fault_i);
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == REG_LOWER_LIMIT) lower_mv = cfg_data_i;
        else if (cfg_index_i == REG_UPPER_LIMIT) upper_mv = cfg_data_i;
      end
      if (in_valid_i && in_ready_i) begin
        if (req_type_i == REQ_WRITE) begin
          if (point_index_i < SciPoints) begin
            curve_x[point_index_i] = point_x_mv_i;
            curve_y[point_index_i] = point_y_i;
          end
        end else begin
          expected_readings.push_back(interpolate_reading(voltage_mv_i));
        end
      end
    end
    pending_o = expected_readings.size();
  end

endmodule

>>> dv/tb_sensor_curve_interpolator.sv
`timescale 1ns / 100ps

module tb_sensor_curve_interpolator;
  import sci_pkg::*;

  // cycle bound for the whole run, above the length of any correct run
  localparam int CycleLimit   = 2000000;
  // margin beyond the longest block latency for eight breakpoints
  localparam int SettleCycles = 50;
  // receiver hold-off that backs the block up into its input
  localparam int LongHold     = 600;
  localparam int Phases       = 16;
  localparam int PhaseItems   = 72;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CfgIdxW-1:0]   cfg_index_i;
  logic [XW-1:0]        cfg_data_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic                 req_type_i;
  logic [XW-1:0]        voltage_mv_i;
  logic [2:0]           point_index_i;
  logic [XW-1:0]        point_x_mv_i;
  logic signed [YW-1:0] point_y_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic signed [YW-1:0] value_o;
  logic [1:0]           fault_o;

  int                   mismatches;
  int                   pending;
  int                   cycle_count = 0;

  // stimulus-side copies, used only to aim voltages at interesting spots
  logic [XW-1:0]        shadow_x [SciPoints];
  logic [XW-1:0]        lower_mv;
  logic [XW-1:0]        upper_mv;

  // pacing knobs shared by sender and receiver
  bit                   tx_burst = 1'b0;
  bit                   rx_burst = 1'b0;
  int                   holds_wanted = 0;
  int                   holds_served = 0;

  always #10 clk_i = ~clk_i;

  sensor_curve_interpolator DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .req_type_i   (req_type_i),
    .voltage_mv_i (voltage_mv_i),
    .point_index_i(point_index_i),
    .point_x_mv_i (point_x_mv_i),
    .point_y_i    (point_y_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .value_o      (value_o),
    .fault_o      (fault_o)
  );

  // checker watches all three channels, predicts and compares
  sci_reading_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_i     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .req_type_i      (req_type_i),
    .voltage_mv_i    (voltage_mv_i),
    .point_index_i   (point_index_i),
    .point_x_mv_i    (point_x_mv_i),
    .point_y_i       (point_y_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .value_i         (value_o),
    .fault_i         (fault_o),
    .mismatch_count_o(mismatches),
    .pending_o       (pending)
  );

  // watchdog: a hang anywhere ends the run as a failure
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // idle length: mostly none, sometimes a few cycles, rarely a long gap
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    else if (r < 95) return $urandom_range(1, 4);
    else return $urandom_range(20, 80);
  endfunction

  // breakpoint values lean on the Q16.16 extremes
  function automatic logic [YW-1:0] random_y();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 32'h8000_0000;
    else if (r < 20) return 32'h7fff_ffff;
    else if (r < 25) return '0;
    else if (r < 35) return $urandom_range(0, 131072) - 65536;
    else return $urandom;
  endfunction

  // voltages aimed at breakpoints, segment edges and the limit edges
  function automatic logic [XW-1:0] pick_voltage();
    int            r;
    int            k;
    logic [XW-1:0] v;
    r = $urandom_range(0, 99);
    k = $urandom_range(0, SciPoints - 1);
    if (r < 35) begin
      v = shadow_x[k] + XW'($urandom_range(0, 3));
    end else if (r < 45) begin
      v = shadow_x[k] - 1'b1;
    end else if (r < 55) begin
      case ($urandom_range(0, 3))
        0:       v = lower_mv;
        1:       v = lower_mv - 1'b1;
        2:       v = upper_mv;
        default: v = upper_mv + 1'b1;
      endcase
    end else begin
      v = XW'($urandom_range(0, 4095));
    end
    return v;
  endfunction

  // one input transaction; valid stays up across back-to-back items
  task automatic drive_item(input sci_req_e req, input logic [XW-1:0] mv,
                            input logic [2:0] idx, input logic [XW-1:0] px,
                            input logic [YW-1:0] py);
    int gap;
    gap = tx_burst ? 0 : idle_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    req_type_i    <= req;
    voltage_mv_i  <= mv;
    point_index_i <= idx;
    point_x_mv_i  <= px;
    point_y_i     <= py;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // unused payload fields carry random bits
  task automatic send_sample(input logic [XW-1:0] mv);
    drive_item(REQ_SAMPLE, mv, 3'($urandom), 12'($urandom), $urandom);
  endtask

  task automatic send_point(input logic [2:0] idx, input logic [XW-1:0] px,
                            input logic [YW-1:0] py);
    shadow_x[idx] = px;
    drive_item(REQ_WRITE, 12'($urandom), idx, px, py);
  endtask

  // drain: let the last transaction be counted, wait until nothing is outstanding,
  // then wait SettleCycles for a trailing write to land
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // both limit registers back to back, only while the block is idle
  task automatic write_limits(input logic [XW-1:0] lo, input logic [XW-1:0] hi);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= REG_LOWER_LIMIT;
    cfg_data_i  <= lo;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_index_i <= REG_UPPER_LIMIT;
    cfg_data_i  <= hi;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    lower_mv = lo;
    upper_mv = hi;
  endtask

  // full sorted table: wide spread, tight cluster with repeats, or coarse steps
  task automatic load_table();
    int mode;
    int x;
    mode = $urandom_range(0, 2);
    if (mode == 1) x = $urandom_range(0, 4000);
    else x = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 600);
    for (int k = 0; k < SciPoints; k++) begin
      send_point(3'(k), XW'(x), random_y());
      case (mode)
        0:       x += $urandom_range(0, 600);
        1:       x += $urandom_range(0, 6);
        default: x += $urandom_range(0, 1200);
      endcase
      if (x > 4095) x = 4095;
    end
  endtask

  // receiver: random ready pattern, burst stretches, and the long hold-off
  initial begin
    int len;
    bit ready;
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (holds_served < holds_wanted) begin
        out_ready_i <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
        holds_served++;
      end else if (rx_burst) begin
        out_ready_i <= 1'b1;
        @(posedge clk_i);
      end else begin
        ready = ($urandom_range(0, 99) < 65);
        len   = idle_len() + 1;
        out_ready_i <= ready;
        repeat (len) @(posedge clk_i);
      end
    end
  end

  // stimulus and verdict
  initial begin
    logic [XW-1:0] lo;
    logic [XW-1:0] hi;
    logic [XW-1:0] a;
    logic [XW-1:0] b;
    rst_ni        <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= REG_LOWER_LIMIT;
    cfg_data_i    <= '0;
    in_valid_i    <= 1'b0;
    req_type_i    <= REQ_SAMPLE;
    voltage_mv_i  <= '0;
    point_index_i <= '0;
    point_x_mv_i  <= '0;
    point_y_i     <= '0;
    lower_mv = '0;
    upper_mv = '1;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    settle();

    // crossed limits: every sample is rejected before the table is touched,
    // so this runs safely on the unwritten table
    write_limits(12'd3000, 12'd100);
    send_sample(12'd0);
    send_sample(12'd4095);
    send_sample(12'd1500);
    settle();

    // full-range limits and a hand-built table: Q16.16 extremes at both ends
    // of segment 0, a falling segment, and a zero-width segment (1000..1000)
    write_limits(12'd0, 12'd4095);
    send_point(3'd0, 12'd0,    32'h8000_0000);
    send_point(3'd1, 12'd10,   32'h7fff_ffff);
    send_point(3'd2, 12'd500,  32'h0000_0000);
    send_point(3'd3, 12'd1000, 32'h0001_0000);
    send_point(3'd4, 12'd1000, 32'hffff_0000);
    send_point(3'd5, 12'd2000, 32'h1234_5678);
    send_point(3'd6, 12'd3000, 32'hffff_fffb);
    send_point(3'd7, 12'd4000, 32'h0000_0007);
    send_sample(12'd0);
    send_sample(12'd5);
    send_sample(12'd9);
    send_sample(12'd10);
    send_sample(12'd999);
    send_sample(12'd1000);
    send_sample(12'd3999);
    // at or past the last breakpoint: no segment matches
    send_sample(12'd4000);
    send_sample(12'd4095);
    settle();

    // narrowed limits, probed on both sides of each edge
    write_limits(12'd100, 12'd3900);
    send_sample(12'd99);
    send_sample(12'd100);
    send_sample(12'd3900);
    send_sample(12'd3901);

    // random phases: new limits, usually a fresh sorted table, then a mix of
    // samples and stray single-point writes that break the ordering
    for (int phase = 0; phase < Phases; phase++) begin
      settle();
      a = XW'($urandom_range(0, 4095));
      b = XW'($urandom_range(0, 4095));
      case (phase % 6)
        0: begin lo = 12'd0; hi = 12'd4095; end
        1: begin lo = (a < b) ? a : b; hi = (a < b) ? b : a; end
        2: begin lo = 12'd4095; hi = 12'd4095; end
        3: begin
          // crossed limits reject everything
          lo = (a > b) ? a : b;
          hi = (a > b) ? b : a;
          if (lo == hi) begin
            lo = 12'd4095;
            hi = 12'd0;
          end
        end
        4: begin lo = 12'd0; hi = 12'd0; end
        default: begin
          lo = XW'($urandom_range(0, 200));
          hi = XW'($urandom_range(3800, 4095));
        end
      endcase
      write_limits(lo, hi);

      tx_burst = (phase % 4 == 1) || (phase % 4 == 3);
      rx_burst = (phase % 4 == 1) || (phase % 4 == 2);
      if (phase == 6) begin
        // receiver stops while the sender keeps pushing
        tx_burst = 1'b1;
        holds_wanted++;
      end

      if (phase == 0 || $urandom_range(0, 2) != 0) load_table();
      for (int n = 0; n < PhaseItems; n++) begin
        if ($urandom_range(0, 99) < 10)
          send_point(3'($urandom_range(0, SciPoints - 1)), XW'($urandom_range(0, 4095)),
                     $urandom);
        else
          send_sample(pick_voltage());
      end
    end

    settle();
    if (mismatches == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
